### rtl/um32_pkg.sv
// ----------------------------------------------------------------------------
// um32_pkg: shared types and constants of the UM-32 execute unit
// Result kinds, opcodes, field positions, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package um32_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int OP_W      = 4;
   localparam int IMM_W     = 25;

   // instruction field positions
   localparam int OP_LSB = 28;
   localparam int RI_LSB = 25;
   localparam int RA_LSB = 6;
   localparam int RB_LSB = 3;
   localparam int RC_LSB = 0;

   localparam int CHAR_W = 8;

   typedef enum logic [3:0] {
      K_DONE       = 4'd0,
      K_LOAD       = 4'd1,
      K_STORE      = 4'd2,
      K_ALLOC      = 4'd3,
      K_FREE       = 4'd4,
      K_OUT        = 4'd5,
      K_IN         = 4'd6,
      K_LOADPROG   = 4'd7,
      K_HALT       = 4'd8,
      K_BADOP      = 4'd9,
      K_DIV0       = 4'd10,
      K_UNEXPECTED = 4'd11
   } kind_type;

   localparam logic [OP_W-1:0] OP_CMOV     = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_W-1:0] OP_STORE    = 4'd2;
   localparam logic [OP_W-1:0] OP_ADD      = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL      = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV      = 4'd5;
   localparam logic [OP_W-1:0] OP_NAND     = 4'd6;
   localparam logic [OP_W-1:0] OP_HALT     = 4'd7;
   localparam logic [OP_W-1:0] OP_ALLOC    = 4'd8;
   localparam logic [OP_W-1:0] OP_FREE     = 4'd9;
   localparam logic [OP_W-1:0] OP_OUT      = 4'd10;
   localparam logic [OP_W-1:0] OP_IN       = 4'd11;
   localparam logic [OP_W-1:0] OP_LOADPROG = 4'd12;
   localparam logic [OP_W-1:0] OP_IMM      = 4'd13;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_RD_C,
      S_RD_A,
      S_OPA,
      S_EXEC,
      S_DIV,
      S_WB
   } state_type;

   typedef enum logic [1:0] {
      RD_B,
      RD_C,
      RD_A
   } rd_sel_type;

   typedef enum logic [2:0] {
      WS_REPLY,
      WS_IMM,
      WS_MOVE,
      WS_ADD,
      WS_NAND,
      WS_PROD,
      WS_QUO
   } wsrc_type;

   typedef enum logic [1:0] {
      WD_A,
      WD_IMM,
      WD_PEND
   } wdst_type;

   typedef enum logic [1:0] {
      AW_A,
      AW_B,
      AW_C
   } await_sel_type;

   typedef enum logic [1:0] {
      PC_HOLD,
      PC_INC,
      PC_JUMP
   } pc_op_type;

   typedef struct packed {
      logic          cap_item;
      rd_sel_type    rd_sel;
      logic          cap_b;
      logic          cap_c;
      logic          cap_a;
      logic          cap_prod;
      logic          div_start;
      logic          wr_en;
      wsrc_type      wr_src;
      wdst_type      wr_dst;
      logic          emit;
      kind_type      kind;
      pc_op_type     pc_op;
      logic          set_halt;
      logic          set_await;
      await_sel_type await_dst;
      logic          clr_await;
   } cmd_type;

   typedef struct packed {
      logic            func;
      logic [OP_W-1:0] op;
      logic            halted;
      logic            awaiting;
      logic            vb_zero;
      logic            vc_zero;
      logic            div_done;
   } stat_type;

endpackage

### rtl/um32_req_if.sv
// ----------------------------------------------------------------------------
// um32_req_if: input channel of the UM-32 execute unit
// Valid/ready channel carrying an instruction word or a reply word.
// ----------------------------------------------------------------------------
interface um32_req_if;
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [um32_pkg::WORD_W-1:0]  word;

   modport source (output valid, output func, output word, input ready);
   modport sink   (input valid, input func, input word, output ready);
endinterface

### rtl/um32_rsp_if.sv
// ----------------------------------------------------------------------------
// um32_rsp_if: result channel of the UM-32 execute unit
// Valid/ready channel carrying the result kind, request operands and pc.
// ----------------------------------------------------------------------------
interface um32_rsp_if;
   logic                         valid;
   logic                         ready;
   um32_pkg::kind_type           kind;
   logic [um32_pkg::WORD_W-1:0]  arg_a;
   logic [um32_pkg::WORD_W-1:0]  arg_b;
   logic [um32_pkg::WORD_W-1:0]  arg_c;
   logic [um32_pkg::WORD_W-1:0]  next_pc;

   modport source (output valid, output kind, output arg_a, output arg_b, output arg_c,
                   output next_pc, input ready);
   modport sink   (input valid, input kind, input arg_a, input arg_b, input arg_c,
                   input next_pc, output ready);
endinterface

### rtl/um32_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// um32_instruction_execute_unit: execute core of the UM-32 machine
// The input channel req_port carries either a fetched instruction word
// (func 0) or the reply word to an earlier load, alloc or input request
// (func 1). Each accepted beat yields exactly one beat on rsp_port: a kind,
// up to three request operands and the program counter after the item.
// Items are handled one at a time. Replies, load-immediate, halt, bad
// opcodes and any item refused as unexpected or after halt finish in the
// check state; register ops and requests first read their three operands
// in turn through the single register file read port; multiply also
// registers the product, and divide waits for the one-bit-per-cycle
// divider. The core returns to idle between items.
// The result register frees the core: the next item is accepted while a
// result still waits, and the core stalls only when it must emit a second.
// Synchronous reset clears the registers (they read as zero until written),
// the pc, the pending-reply state and the halt flag; nothing needs clearing.
// ----------------------------------------------------------------------------
module um32_instruction_execute_unit (
   input  logic         clock,
   input  logic         reset,
   um32_req_if.sink     req_port,
   um32_rsp_if.source   rsp_port
);
   import um32_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   um32_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   um32_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_func    (req_port.func),
      .req_word    (req_port.word),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_kind    (rsp_port.kind),
      .rsp_arg_a   (rsp_port.arg_a),
      .rsp_arg_b   (rsp_port.arg_b),
      .rsp_arg_c   (rsp_port.arg_c),
      .rsp_next_pc (rsp_port.next_pc)
   );

endmodule

### rtl/um32_ram.sv
// ----------------------------------------------------------------------------
// um32_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module um32_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/um32_div.sv
// ----------------------------------------------------------------------------
// um32_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module um32_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [um32_pkg::WORD_W-1:0] dividend,
   input  logic [um32_pkg::WORD_W-1:0] divisor,
   output logic                        done,
   output logic [um32_pkg::WORD_W-1:0] quotient
);
   import um32_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it did not go negative
         rem_in = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], ~diff[WORD_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

### rtl/um32_dp.sv
// ----------------------------------------------------------------------------
// um32_dp: datapath of the UM-32 execute unit
// Register file, operand and product registers, pc, pending-reply state,
// halt flag, the divider and the result register.
// ----------------------------------------------------------------------------
module um32_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_func,
   input  logic [um32_pkg::WORD_W-1:0] req_word,
   input  um32_pkg::cmd_type           cmd,
   output um32_pkg::stat_type          stat,
   output um32_pkg::kind_type          rsp_kind,
   output logic [um32_pkg::WORD_W-1:0] rsp_arg_a,
   output logic [um32_pkg::WORD_W-1:0] rsp_arg_b,
   output logic [um32_pkg::WORD_W-1:0] rsp_arg_c,
   output logic [um32_pkg::WORD_W-1:0] rsp_next_pc
);
   import um32_pkg::*;

   logic                 func_ff;
   logic [WORD_W-1:0]    word_ff;
   logic [WORD_W-1:0]    va_ff, vb_ff, vc_ff, prod_ff;
   logic [WORD_W-1:0]    pc_ff, pc_in;
   logic [REG_IDX_W-1:0] pend_ff, pend_in;
   logic                 await_ff, await_in;
   logic                 halt_ff, halt_in;
   logic [NUM_REGS-1:0]  valid_ff, valid_in;
   logic [REG_IDX_W-1:0] rd_addr, rd_addr_ff;
   logic [WORD_W-1:0]    ram_q, rd_val;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    div_quo;
   logic                 div_done;
   logic [REG_IDX_W-1:0] ia, ib, ic, ii;
   logic [WORD_W-1:0]    arg_a, arg_b, arg_c;

   kind_type             kind_ff;
   logic [WORD_W-1:0]    arg_a_ff, arg_b_ff, arg_c_ff, npc_ff;

   assign ia = word_ff[RA_LSB +: REG_IDX_W];
   assign ib = word_ff[RB_LSB +: REG_IDX_W];
   assign ic = word_ff[RC_LSB +: REG_IDX_W];
   assign ii = word_ff[RI_LSB +: REG_IDX_W];

   um32_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   um32_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (vb_ff),
      .divisor  (vc_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // a register never written reads as zero
   assign rd_val = valid_ff[rd_addr_ff] ? ram_q : '0;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_B:    rd_addr = ib;
         RD_C:    rd_addr = ic;
         RD_A:    rd_addr = ia;
         default: rd_addr = ib;
      endcase

      unique case (cmd.wr_dst)
         WD_A:    wr_addr = ia;
         WD_IMM:  wr_addr = ii;
         WD_PEND: wr_addr = pend_ff;
         default: wr_addr = ia;
      endcase

      unique case (cmd.wr_src)
         WS_REPLY: wr_data = word_ff;
         WS_IMM:   wr_data = WORD_W'(word_ff[IMM_W-1:0]);
         WS_MOVE:  wr_data = vb_ff;
         WS_ADD:   wr_data = vb_ff + vc_ff;
         WS_NAND:  wr_data = ~(vb_ff & vc_ff);
         WS_PROD:  wr_data = prod_ff;
         WS_QUO:   wr_data = div_quo;
         default:  wr_data = '0;
      endcase
      wr_en = cmd.wr_en;

      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      unique case (cmd.pc_op)
         PC_HOLD: pc_in = pc_ff;
         PC_INC:  pc_in = pc_ff + 1'b1;
         PC_JUMP: pc_in = vc_ff;
         default: pc_in = pc_ff;
      endcase

      pend_in  = pend_ff;
      await_in = await_ff;
      if (cmd.set_await) begin
         await_in = 1'b1;
         unique case (cmd.await_dst)
            AW_A:    pend_in = ia;
            AW_B:    pend_in = ib;
            AW_C:    pend_in = ic;
            default: pend_in = ia;
         endcase
      end else if (cmd.clr_await) begin
         await_in = 1'b0;
      end
      halt_in = halt_ff | cmd.set_halt;

      arg_a = '0;
      arg_b = '0;
      arg_c = '0;
      unique case (cmd.kind)
         K_LOAD: begin
            arg_a = vb_ff;
            arg_b = vc_ff;
         end
         K_STORE: begin
            arg_a = va_ff;
            arg_b = vb_ff;
            arg_c = vc_ff;
         end
         K_ALLOC, K_FREE: begin
            arg_a = vc_ff;
         end
         K_OUT: begin
            arg_a = WORD_W'(vc_ff[CHAR_W-1:0]);
         end
         K_LOADPROG: begin
            arg_a = vb_ff;
            arg_b = vc_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         pend_ff  <= '0;
         await_ff <= 1'b0;
         halt_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (cmd.emit) begin
            pc_ff <= pc_in;
         end
         if (cmd.emit) begin
            pend_ff  <= pend_in;
            await_ff <= await_in;
            halt_ff  <= halt_in;
         end
         valid_ff <= valid_in;
      end
      rd_addr_ff <= rd_addr;
      if (cmd.cap_item) begin
         func_ff <= req_func;
         word_ff <= req_word;
      end
      if (cmd.cap_b) begin
         vb_ff <= rd_val;
      end
      if (cmd.cap_c) begin
         vc_ff <= rd_val;
      end
      if (cmd.cap_a) begin
         va_ff <= rd_val;
      end
      if (cmd.cap_prod) begin
         prod_ff <= vb_ff * vc_ff;
      end
      if (cmd.emit) begin
         kind_ff  <= cmd.kind;
         arg_a_ff <= arg_a;
         arg_b_ff <= arg_b;
         arg_c_ff <= arg_c;
         npc_ff   <= pc_in;
      end
   end

   assign stat.func     = func_ff;
   assign stat.op       = word_ff[OP_LSB +: OP_W];
   assign stat.halted   = halt_ff;
   assign stat.awaiting = await_ff;
   assign stat.vb_zero  = (vb_ff == '0);
   assign stat.vc_zero  = (vc_ff == '0);
   assign stat.div_done = div_done;

   assign rsp_kind    = kind_ff;
   assign rsp_arg_a   = arg_a_ff;
   assign rsp_arg_b   = arg_b_ff;
   assign rsp_arg_c   = arg_c_ff;
   assign rsp_next_pc = npc_ff;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_no_await_halted: assert property (@(posedge clock) disable iff (reset)
      !(await_ff && halt_ff))
      else $error("halted while a reply is pending");

endmodule

### rtl/um32_ctrl.sv
// ----------------------------------------------------------------------------
// um32_ctrl: sequencer of the UM-32 execute unit
// Accepts one item at a time, steps operand reads, execution and result
// emission, and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module um32_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  um32_pkg::stat_type stat,
   output um32_pkg::cmd_type  cmd
);
   import um32_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.cap_item = req_valid;
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            cmd.rd_sel = RD_B;
            priority if (stat.halted) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_HALT;
                  state_in = S_IDLE;
               end
            end else if (stat.func) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
                  if (stat.awaiting) begin
                     cmd.kind      = K_DONE;
                     cmd.wr_en     = 1'b1;
                     cmd.wr_src    = WS_REPLY;
                     cmd.wr_dst    = WD_PEND;
                     cmd.clr_await = 1'b1;
                  end else begin
                     cmd.kind = K_UNEXPECTED;
                  end
               end
            end else if (stat.awaiting) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_UNEXPECTED;
                  state_in = S_IDLE;
               end
            end else if (stat.op == OP_IMM) begin
               if (out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.kind   = K_DONE;
                  cmd.wr_en  = 1'b1;
                  cmd.wr_src = WS_IMM;
                  cmd.wr_dst = WD_IMM;
                  cmd.pc_op  = PC_INC;
                  state_in   = S_IDLE;
               end
            end else if (stat.op == OP_HALT || stat.op > OP_IMM) begin
               if (out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.kind     = (stat.op == OP_HALT) ? K_HALT : K_BADOP;
                  cmd.set_halt = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_RD_C;
            end
         end

         S_RD_C: begin
            cmd.rd_sel = RD_C;
            cmd.cap_b  = 1'b1;
            state_in   = S_RD_A;
         end

         S_RD_A: begin
            cmd.rd_sel = RD_A;
            cmd.cap_c  = 1'b1;
            state_in   = S_OPA;
         end

         S_OPA: begin
            cmd.cap_a = 1'b1;
            state_in  = S_EXEC;
         end

         S_EXEC: begin
            unique case (stat.op)
               OP_MUL: begin
                  cmd.cap_prod = 1'b1;
                  state_in     = S_WB;
               end
               OP_DIV: begin
                  if (!stat.vc_zero) begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end else if (out_free) begin
                     cmd.emit     = 1'b1;
                     cmd.kind     = K_DIV0;
                     cmd.set_halt = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  // hold until the result register can take the beat
                  if (out_free) begin
                     cmd.emit   = 1'b1;
                     cmd.kind   = K_DONE;
                     cmd.pc_op  = PC_INC;
                     cmd.wr_dst = WD_A;
                     state_in   = S_IDLE;
                     unique case (stat.op)
                        OP_CMOV: begin
                           cmd.wr_en  = !stat.vc_zero;
                           cmd.wr_src = WS_MOVE;
                        end
                        OP_LOAD: begin
                           cmd.kind      = K_LOAD;
                           cmd.set_await = 1'b1;
                           cmd.await_dst = AW_A;
                        end
                        OP_STORE: cmd.kind = K_STORE;
                        OP_ADD: begin
                           cmd.wr_en  = 1'b1;
                           cmd.wr_src = WS_ADD;
                        end
                        OP_NAND: begin
                           cmd.wr_en  = 1'b1;
                           cmd.wr_src = WS_NAND;
                        end
                        OP_ALLOC: begin
                           cmd.kind      = K_ALLOC;
                           cmd.set_await = 1'b1;
                           cmd.await_dst = AW_B;
                        end
                        OP_FREE: cmd.kind = K_FREE;
                        OP_OUT:  cmd.kind = K_OUT;
                        OP_IN: begin
                           cmd.kind      = K_IN;
                           cmd.set_await = 1'b1;
                           cmd.await_dst = AW_C;
                        end
                        OP_LOADPROG: begin
                           cmd.kind  = stat.vb_zero ? K_DONE : K_LOADPROG;
                           cmd.pc_op = PC_JUMP;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            endcase
         end

         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_WB;
            end
         end

         S_WB: begin
            if (out_free) begin
               cmd.emit   = 1'b1;
               cmd.kind   = K_DONE;
               cmd.wr_en  = 1'b1;
               cmd.wr_src = (stat.op == OP_MUL) ? WS_PROD : WS_QUO;
               cmd.wr_dst = WD_A;
               cmd.pc_op  = PC_INC;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait");

endmodule
